// ===== rtl/core/edas_pkg.sv =====
// shared types, constants and the angle wrap function of the angle damper
package edas_pkg;

    // angle fixed point: fraction bits of one degree
    localparam int ANGLE_FRAC_BITS = 7;

    // one lane per axis
    localparam int NUM_LANES  = 3;
    localparam int LANE_PITCH = 0;
    localparam int LANE_YAW   = 1;
    localparam int LANE_ROLL  = 2;

    typedef logic signed [15:0] t_angle;
    typedef logic signed [18:0] t_wide_angle;
    typedef logic signed [16:0] t_delta;
    typedef logic        [16:0] t_alpha;

    typedef struct packed {
        t_angle pitch;
        t_angle yaw;
        t_angle roll;
    } t_triple;

    localparam t_wide_angle HALF_TURN = t_wide_angle'(180 << ANGLE_FRAC_BITS);
    localparam t_wide_angle FULL_TURN = t_wide_angle'(360 << ANGLE_FRAC_BITS);

    // Q16 coefficients of the exponential approximation
    localparam logic [15:0] LN2_Q16   = 16'd45426;
    localparam logic [14:0] C2_Q16    = 15'd31457;
    localparam logic [13:0] C3_Q16    = 14'd15401;
    localparam t_alpha      ONE_Q16   = 17'h10000;
    localparam logic [23:0] X_MAX_Q16 = 24'h800000;

    // pipeline depths
    localparam int DIV1_STEPS = 24;
    localparam int DIV2_STEPS = 17;
    localparam int ALPHA_LAT  = DIV1_STEPS + DIV2_STEPS + 8;
    localparam int DELTA_DLY  = ALPHA_LAT - 2;
    localparam int PIPE_LAT   = ALPHA_LAT + 3;
    localparam int CUR_DLY    = PIPE_LAT - 1;

    // configuration register map
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index  CFG_HALF_LIFE       = 2'd0;
    localparam t_cfg_index  CFG_CCW_THRESHOLD   = 2'd1;
    localparam logic [15:0] HALF_LIFE_RESET     = 16'd410;
    localparam logic [14:0] CCW_THRESHOLD_RESET = 15'd0;

    // map an angle in (-5/2 turn, 3/2 turn] into (-half turn, half turn]
    function automatic t_angle wrap_angle(input t_wide_angle v);
        t_wide_angle r;
        if (v > HALF_TURN) begin
            r = v - FULL_TURN;
        end else if (v <= -HALF_TURN - FULL_TURN) begin
            r = v + FULL_TURN + FULL_TURN;
        end else if (v <= -HALF_TURN) begin
            r = v + FULL_TURN;
        end else begin
            r = v;
        end
        return t_angle'(r);
    endfunction

endpackage

// ===== rtl/core/edas_alpha.sv =====
// pipelined damping factor: x = ln2*dt/half_life, alpha = 1 - 1/(1+x+0.48x^2+0.235x^3)
module edas_alpha (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [15:0]          i_elapsed_time,
    input  logic [15:0]          i_half_life,
    output edas_pkg::t_alpha     o_alpha
);
    import edas_pkg::*;

    logic [15:0]           w_hl;
    logic [31:0]           w_num;

    // first divider: numerator bits and remainder per step
    logic [15:0]           r_xrem [DIV1_STEPS];
    logic [DIV1_STEPS-1:0] r_xlow [DIV1_STEPS];
    logic [DIV1_STEPS-1:0] r_xquo [1:DIV1_STEPS];
    logic                  r_xovf [1:DIV1_STEPS];

    // polynomial
    logic [23:0]           r_x;
    logic [23:0]           r_xa;
    logic [23:0]           r_xb;
    logic [23:0]           r_xc;
    logic [30:0]           r_x2;
    logic [37:0]           r_x3;
    logic [29:0]           r_c2t;
    logic [29:0]           r_c2b;
    logic [35:0]           r_c3t;
    logic [35:0]           r_d;
    logic [47:0]           w_x2p;
    logic [54:0]           w_x3p;
    logic [45:0]           w_c2p;
    logic [51:0]           w_c3p;
    logic [36:0]           w_m;

    // second divider: reciprocal of the denominator
    logic [35:0]           r_erem [DIV2_STEPS];
    logic [DIV2_STEPS-1:0] r_elow [DIV2_STEPS];
    logic [35:0]           r_ed   [DIV2_STEPS];
    logic [DIV2_STEPS-1:0] r_equo [1:DIV2_STEPS];
    logic [DIV2_STEPS-1:0] w_e;
    t_alpha                r_alpha;

    // zero half-life counts as one unit; rounded numerator
    assign w_hl  = (i_half_life == 16'd0) ? 16'd1 : i_half_life;
    assign w_num = 32'(LN2_Q16) * 32'(i_elapsed_time) + 32'(w_hl >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xrem[0] <= 16'(w_num[31:DIV1_STEPS]);
            r_xlow[0] <= w_num[DIV1_STEPS-1:0];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_xdiv
        logic [16:0] w_t;
        logic        w_ge;
        assign w_t  = {r_xrem[k], r_xlow[k][DIV1_STEPS-1-k]};
        assign w_ge = w_t >= {1'b0, w_hl};

        if (k + 1 < DIV1_STEPS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_xrem[k+1] <= w_ge ? 16'(w_t - {1'b0, w_hl}) : w_t[15:0];
                    r_xlow[k+1] <= r_xlow[k];
                end
            end
        end

        if (k == 0) begin : g_head
            // quotient would need more than the kept bits
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_xquo[1] <= DIV1_STEPS'(w_ge);
                    r_xovf[1] <= r_xrem[0] >= w_hl;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_xquo[k+1] <= {r_xquo[k][DIV1_STEPS-2:0], w_ge};
                    r_xovf[k+1] <= r_xovf[k];
                end
            end
        end
    end

    // saturate x at 128.0
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_xovf[DIV1_STEPS] || (r_xquo[DIV1_STEPS] > X_MAX_Q16)) begin
                r_x <= X_MAX_Q16;
            end else begin
                r_x <= r_xquo[DIV1_STEPS];
            end
        end
    end

    // x^2, then x^3 and the quadratic term, then the cubic term
    assign w_x2p = 48'(r_x) * 48'(r_x) + 48'd32768;
    assign w_x3p = 55'(r_x2) * 55'(r_xa) + 55'd32768;
    assign w_c2p = 46'(C2_Q16) * 46'(r_x2) + 46'd32768;
    assign w_c3p = 52'(C3_Q16) * 52'(r_x3) + 52'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2  <= 31'(w_x2p >> 16);
            r_xa  <= r_x;
            r_x3  <= 38'(w_x3p >> 16);
            r_c2t <= 30'(w_c2p >> 16);
            r_xb  <= r_xa;
            r_c3t <= 36'(w_c3p >> 16);
            r_c2b <= r_c2t;
            r_xc  <= r_xb;
            r_d   <= 36'(ONE_Q16) + 36'(r_xc) + 36'(r_c2b) + r_c3t;
        end
    end

    // rounded 2^32 / d
    assign w_m = 37'h1_0000_0000 + 37'(r_d >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_erem[0] <= 36'(w_m >> DIV2_STEPS);
            r_elow[0] <= w_m[DIV2_STEPS-1:0];
            r_ed[0]   <= r_d;
        end
    end

    for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_ediv
        logic [36:0] w_t;
        logic        w_ge;
        assign w_t  = {r_erem[k], r_elow[k][DIV2_STEPS-1-k]};
        assign w_ge = w_t >= {1'b0, r_ed[k]};

        if (k + 1 < DIV2_STEPS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_erem[k+1] <= w_ge ? 36'(w_t - {1'b0, r_ed[k]}) : w_t[35:0];
                    r_elow[k+1] <= r_elow[k];
                    r_ed[k+1]   <= r_ed[k];
                end
            end
        end

        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_equo[1] <= DIV2_STEPS'(w_ge);
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_equo[k+1] <= {r_equo[k][DIV2_STEPS-2:0], w_ge};
                end
            end
        end
    end

    // alpha = 1 - e, e limited to 1.0
    assign w_e = (r_equo[DIV2_STEPS] > ONE_Q16) ? ONE_Q16 : r_equo[DIV2_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_alpha <= ONE_Q16 - w_e;
        end
    end

    assign o_alpha = r_alpha;

endmodule

// ===== rtl/core/edas_lane.sv =====
// one axis lane: biased wrapped difference, scale by alpha, add back and wrap
module edas_lane (
    input  logic             i_clk,
    input  logic             i_en,
    input  edas_pkg::t_angle i_current,
    input  edas_pkg::t_angle i_target,
    input  logic [14:0]      i_ccw_threshold,
    input  edas_pkg::t_alpha i_alpha,
    output edas_pkg::t_angle o_smoothed
);
    import edas_pkg::*;

    t_angle      r_cur [CUR_DLY];
    t_angle      r_diff;
    t_delta      r_delta;
    t_delta      r_dly [DELTA_DLY];
    t_wide_angle w_diff_x;
    t_wide_angle w_lim;
    t_delta      w_delta;
    logic        w_neg;
    logic [15:0] w_mag;
    logic [32:0] r_pmag;
    logic        r_neg;
    logic [15:0] w_rnd;
    t_delta      r_step;
    t_angle      r_out;

    // wrapped difference, then the counter-clockwise bias
    assign w_diff_x = t_wide_angle'(r_diff);
    assign w_lim    = HALF_TURN - t_wide_angle'(i_ccw_threshold);
    assign w_delta  = (w_diff_x > w_lim) ? t_delta'(w_diff_x - FULL_TURN) : t_delta'(w_diff_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff  <= wrap_angle(t_wide_angle'(i_target) - t_wide_angle'(i_current));
            r_delta <= w_delta;
        end
    end

    // delay lines that wait for alpha
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cur[0] <= i_current;
            r_dly[0] <= r_delta;
            for (int i = 1; i < CUR_DLY; i++) begin
                r_cur[i] <= r_cur[i-1];
            end
            for (int i = 1; i < DELTA_DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // magnitude times alpha
    assign w_neg = r_dly[DELTA_DLY-1] < 0;
    assign w_mag = w_neg ? 16'(-r_dly[DELTA_DLY-1]) : 16'(r_dly[DELTA_DLY-1]);

    // round half away from zero, then restore the sign
    assign w_rnd = 16'((r_pmag + 33'd32768) >> 16);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pmag <= 33'(w_mag) * 33'(i_alpha);
            r_neg  <= w_neg;
            r_step <= r_neg ? -t_delta'(w_rnd) : t_delta'(w_rnd);
            r_out  <= wrap_angle(t_wide_angle'(r_cur[CUR_DLY-1]) + t_wide_angle'(r_step));
        end
    end

    assign o_smoothed = r_out;

endmodule

// ===== rtl/core/edas_merge.sv =====
// gathers the lane results into one triple, output register with skid stage
module edas_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  edas_pkg::t_angle  i_lane [edas_pkg::NUM_LANES],
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output edas_pkg::t_triple o_result
);
    import edas_pkg::*;

    t_triple w_merged;
    t_triple r_out;
    t_triple r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    w_pop;

    assign w_merged.pitch = i_lane[LANE_PITCH];
    assign w_merged.yaw   = i_lane[LANE_YAW];
    assign w_merged.roll  = i_lane[LANE_ROLL];

    assign w_pop = r_out_valid && i_ready;

    // control: output slot and skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid <= w_merged;
            end else begin
                r_out <= w_merged;
            end
        end
    end

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/core/exact_damper_angle_smoother.sv =====
// top level of the three-axis half-life angle damper
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  input    | i_in_valid / o_in_ready  | current and target pitch/yaw/roll, dt
//  output   | o_out_valid / i_out_ready| smoothed pitch/yaw/roll
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle while the skid entry is free; 53 register stages, most of them in the two
// bit-per-stage dividers of the alpha pipeline (24 and 17 stages).
// Reset loads half_life 410 and ccw_threshold 0 and empties the pipeline.
// An output stall is absorbed by one skid entry; input ready drops in the cycle after a result
// lands in the skid entry, and the whole pipeline holds until the skid entry drains.
module exact_damper_angle_smoother (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  edas_pkg::t_angle     i_current_pitch,
    input  edas_pkg::t_angle     i_current_yaw,
    input  edas_pkg::t_angle     i_current_roll,
    input  edas_pkg::t_angle     i_target_pitch,
    input  edas_pkg::t_angle     i_target_yaw,
    input  edas_pkg::t_angle     i_target_roll,
    input  logic [15:0]          i_elapsed_time,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output edas_pkg::t_angle     o_smoothed_pitch,
    output edas_pkg::t_angle     o_smoothed_yaw,
    output edas_pkg::t_angle     o_smoothed_roll,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  edas_pkg::t_cfg_index i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import edas_pkg::*;

    logic [15:0]         r_half_life;
    logic [14:0]         r_ccw_threshold;
    logic [PIPE_LAT-1:0] r_vld;
    logic                w_en;
    logic                w_push;
    t_alpha              w_alpha;
    t_angle              w_cur  [NUM_LANES];
    t_angle              w_tgt  [NUM_LANES];
    t_angle              w_lane [NUM_LANES];
    t_triple             w_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_life     <= HALF_LIFE_RESET;
            r_ccw_threshold <= CCW_THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HALF_LIFE: begin
                    r_half_life <= i_cfg_data;
                end
                CFG_CCW_THRESHOLD: begin
                    r_ccw_threshold <= i_cfg_data[14:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline advances while the skid slot is free
    assign o_in_ready = w_en;
    assign w_push     = w_en && r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    // shared damping factor
    edas_alpha u_alpha (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_elapsed_time (i_elapsed_time),
        .i_half_life    (r_half_life),
        .o_alpha        (w_alpha)
    );

    // axis lanes
    assign w_cur[LANE_PITCH] = i_current_pitch;
    assign w_cur[LANE_YAW]   = i_current_yaw;
    assign w_cur[LANE_ROLL]  = i_current_roll;
    assign w_tgt[LANE_PITCH] = i_target_pitch;
    assign w_tgt[LANE_YAW]   = i_target_yaw;
    assign w_tgt[LANE_ROLL]  = i_target_roll;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        edas_lane u_lane (
            .i_clk           (i_clk),
            .i_en            (w_en),
            .i_current       (w_cur[g]),
            .i_target        (w_tgt[g]),
            .i_ccw_threshold (r_ccw_threshold),
            .i_alpha         (w_alpha),
            .o_smoothed      (w_lane[g])
        );
    end

    // merge lanes into the output buffer
    edas_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_lane   (w_lane),
        .o_space  (w_en),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_result)
    );

    assign o_smoothed_pitch = w_result.pitch;
    assign o_smoothed_yaw   = w_result.yaw;
    assign o_smoothed_roll  = w_result.roll;

endmodule

// ===== rtl/core/edas_checker.sv =====
// port-level checks of the angle damper and their binding to the top level
module edas_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input edas_pkg::t_angle     o_smoothed_pitch,
    input edas_pkg::t_angle     o_smoothed_yaw,
    input edas_pkg::t_angle     o_smoothed_roll
);
    import edas_pkg::*;

    // a result not taken stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_smoothed_pitch)
            && $stable(o_smoothed_yaw) && $stable(o_smoothed_roll))
        else $error("output result changed while stalled");

    // reset leaves an empty pipeline that takes input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // every result lies in (-180, 180] degrees
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_smoothed_pitch > -HALF_TURN && o_smoothed_pitch <= HALF_TURN
            && o_smoothed_yaw > -HALF_TURN && o_smoothed_yaw <= HALF_TURN
            && o_smoothed_roll > -HALF_TURN && o_smoothed_roll <= HALF_TURN)
        else $error("result outside the wrapped range");

    // input only backs up behind a stalled output transfer
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready dropped without an output stall");

endmodule

bind exact_damper_angle_smoother edas_checker u_edas_checker (.*);

// ===== tb/exact_damper_angle_smoother_test.sv =====
// self-checking testbench of the three-axis half-life angle damper
module exact_damper_angle_smoother_test;

    import edas_pkg::*;

    // register indexes that the block leaves unmapped
    localparam t_cfg_index CFG_SPARE_A = 2'd2;
    localparam t_cfg_index CFG_SPARE_B = 2'd3;

    localparam int HALF_DEG     = 180 << edas_pkg::ANGLE_FRAC_BITS;
    localparam int FULL_DEG     = 360 << edas_pkg::ANGLE_FRAC_BITS;
    localparam int PIPE_SETTLE  = edas_pkg::PIPE_LAT + 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int LONG_HOLD    = 300;

    typedef struct {
        t_angle      cur_p;
        t_angle      cur_y;
        t_angle      cur_r;
        t_angle      tgt_p;
        t_angle      tgt_y;
        t_angle      tgt_r;
        logic [15:0] dt;
    } t_angle_update;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_angle      i_current_pitch = '0;
    t_angle      i_current_yaw = '0;
    t_angle      i_current_roll = '0;
    t_angle      i_target_pitch = '0;
    t_angle      i_target_yaw = '0;
    t_angle      i_target_roll = '0;
    logic [15:0] i_elapsed_time = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_angle      o_smoothed_pitch;
    t_angle      o_smoothed_yaw;
    t_angle      o_smoothed_roll;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index = CFG_HALF_LIFE;
    logic [15:0] i_cfg_data = '0;

    // testbench copy of the configuration, at reset values
    logic [15:0] cfg_half_life = edas_pkg::HALF_LIFE_RESET;
    logic [14:0] cfg_ccw = edas_pkg::CCW_THRESHOLD_RESET;

    t_angle_update pending_updates[$];
    t_triple       smoothed_due[$];
    t_angle_update offered;
    int            queued_total = 0;
    int            accepted_total = 0;
    int            error_count = 0;
    bit            in_taken = 1'b0;
    bit            quiet = 1'b0;
    bit            hold_req = 1'b0;
    bit            hold_served = 1'b0;
    int            hold_left = 0;
    int            send_gap = 0;
    int            stall_left = 0;

    exact_damper_angle_smoother uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_current_pitch  (i_current_pitch),
        .i_current_yaw    (i_current_yaw),
        .i_current_roll   (i_current_roll),
        .i_target_pitch   (i_target_pitch),
        .i_target_yaw     (i_target_yaw),
        .i_target_roll    (i_target_roll),
        .i_elapsed_time   (i_elapsed_time),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_smoothed_pitch (o_smoothed_pitch),
        .o_smoothed_yaw   (o_smoothed_yaw),
        .o_smoothed_roll  (o_smoothed_roll),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock, period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // map any angle into (-half turn, half turn]
    function automatic int wrap_turn(int v);
        int r;
        r = v % FULL_DEG;
        if (r > HALF_DEG) r -= FULL_DEG;
        if (r <= -HALF_DEG) r += FULL_DEG;
        return r;
    endfunction

    // alpha = 1 - 1/(1 + x + 0.48x^2 + 0.235x^3), x = ln2*dt/half_life, Q16
    function automatic logic [16:0] damping_alpha(logic [15:0] dt);
        longint unsigned h, x, x2, x3, d, e;
        h = (cfg_half_life == 16'd0) ? 64'd1 : 64'(cfg_half_life);
        x = (64'd45426 * 64'(dt) + h / 2) / h;
        if (x > 64'd8388608) x = 64'd8388608;
        x2 = (x * x + 64'd32768) >> 16;
        x3 = (x2 * x + 64'd32768) >> 16;
        d = 64'd65536 + x + ((64'd31457 * x2 + 64'd32768) >> 16)
            + ((64'd15401 * x3 + 64'd32768) >> 16);
        e = ((64'd1 << 32) + d / 2) / d;
        if (e > 64'd65536) e = 64'd65536;
        return 17'(64'd65536 - e);
    endfunction

    // one axis: biased shortest delta, scaled by alpha with ties away from zero
    function automatic t_angle damp_axis(t_angle cur, t_angle tgt, logic [16:0] alpha);
        int              delta;
        int              stepv;
        longint          prod;
        longint unsigned mag;
        bit              neg;
        delta = wrap_turn(int'(tgt) - int'(cur));
        if (delta > HALF_DEG - int'(cfg_ccw)) delta -= FULL_DEG;
        prod = longint'(delta) * longint'(alpha);
        neg = prod < 0;
        mag = neg ? longint'(-prod) : prod;
        mag = (mag + 64'd32768) >> 16;
        stepv = neg ? -int'(mag) : int'(mag);
        return t_angle'(wrap_turn(int'(cur) + stepv));
    endfunction

    function automatic t_triple predict_smoothed(t_angle_update u);
        t_triple     r;
        logic [16:0] alpha;
        alpha = damping_alpha(u.dt);
        r.pitch = damp_axis(u.cur_p, u.tgt_p, alpha);
        r.yaw = damp_axis(u.cur_y, u.tgt_y, alpha);
        r.roll = damp_axis(u.cur_r, u.tgt_r, alpha);
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic compare_axis(string axis, t_angle got, t_angle want);
        if (got !== want) begin
            report_error($sformatf("%s got %0d want %0d", axis, got, want));
        end
    endtask

    // sample transfers at the rising edge and check results in order
    always @(posedge i_clk) begin : monitor
        t_triple want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = i_in_valid && o_in_ready;
            if (in_taken) begin
                smoothed_due.push_back(predict_smoothed(offered));
                accepted_total++;
            end
            if (o_out_valid && i_out_ready) begin
                if (smoothed_due.size() == 0) begin
                    report_error("result transfer with nothing expected");
                end else begin
                    want = smoothed_due.pop_front();
                    compare_axis("pitch", o_smoothed_pitch, want.pitch);
                    compare_axis("yaw", o_smoothed_yaw, want.yaw);
                    compare_axis("roll", o_smoothed_roll, want.roll);
                end
            end
        end
    end

    // input driver with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_updates.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 12) - 1;
                i_in_valid <= 1'b0;
            end else begin
                offered = pending_updates.pop_front();
                i_current_pitch <= offered.cur_p;
                i_current_yaw <= offered.cur_y;
                i_current_roll <= offered.cur_r;
                i_target_pitch <= offered.tgt_p;
                i_target_yaw <= offered.tgt_y;
                i_target_roll <= offered.tgt_r;
                i_elapsed_time <= offered.dt;
                i_in_valid <= 1'b1;
            end
        end
    end

    // result receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            hold_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(t_cfg_index idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HALF_LIFE:     cfg_half_life = data;
            CFG_CCW_THRESHOLD: cfg_ccw = data[14:0];
            default:           ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_update(int cp, int cy, int cr, int tp, int ty, int tr, int dt);
        t_angle_update u;
        u.cur_p = t_angle'(cp);
        u.cur_y = t_angle'(cy);
        u.cur_r = t_angle'(cr);
        u.tgt_p = t_angle'(tp);
        u.tgt_y = t_angle'(ty);
        u.tgt_r = t_angle'(tr);
        u.dt = 16'(dt);
        pending_updates.push_back(u);
        queued_total++;
    endtask

    // wait until every queued transfer is done and its result has arrived
    task automatic drain_pipeline();
        while (accepted_total != queued_total || smoothed_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    function automatic int pick_angle();
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: begin
                case ($urandom_range(0, 5))
                    0: return -32768;
                    1: return 32767;
                    2: return -HALF_DEG;
                    3: return HALF_DEG;
                    4: return -HALF_DEG + 1;
                    default: return 0;
                endcase
            end
            default: return int'($urandom_range(0, 2 * HALF_DEG)) - HALF_DEG;
        endcase
    endfunction

    // targets cluster around the bias boundary and the half turn
    function automatic int pick_target(int cur);
        case ($urandom_range(0, 7))
            0, 1: return cur + HALF_DEG - int'(cfg_ccw) + int'($urandom_range(0, 4)) - 2;
            2:    return cur + HALF_DEG + int'($urandom_range(0, 4)) - 2;
            3:    return cur - HALF_DEG + int'($urandom_range(0, 4)) - 2;
            default: return pick_angle();
        endcase
    endfunction

    function automatic int pick_dt();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(1, 16);
            3, 4: return $urandom_range(0, 65535);
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    task automatic queue_random_updates(int n);
        int cp, cy, cr;
        repeat (n) begin
            cp = pick_angle();
            cy = pick_angle();
            cr = pick_angle();
            queue_update(cp, cy, cr, pick_target(cp), pick_target(cy), pick_target(cr),
                         pick_dt());
        end
    endtask

    // settings for each random phase, extremes among them
    task automatic apply_settings(int p);
        logic [15:0] hl;
        logic [15:0] ccw;
        case (p)
            0: begin hl = 16'd410; ccw = 16'd0; end
            1: begin hl = 16'd1; ccw = 16'd0; end
            2: begin hl = 16'd65535; ccw = 16'd23040; end
            3: begin hl = 16'($urandom_range(1, 2000)); ccw = 16'($urandom_range(0, 23040)); end
            4: begin hl = 16'd0; ccw = 16'($urandom_range(0, 65535)); end
            5: begin hl = 16'($urandom_range(0, 65535)); ccw = 16'($urandom_range(0, 23040)); end
            6: begin hl = 16'($urandom_range(1, 64)); ccw = 16'($urandom_range(22000, 23040)); end
            default: begin
                hl = 16'($urandom_range(1, 4000));
                ccw = 16'($urandom_range(0, 32767));
            end
        endcase
        write_reg(CFG_HALF_LIFE, hl);
        write_reg(CFG_CCW_THRESHOLD, ccw);
        if ($urandom_range(0, 1) == 1) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      16'($urandom_range(0, 65535)));
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: exact half turn, zero step, full-range inputs
        queue_update(0, 0, 0, HALF_DEG, -HALF_DEG, 0, 410);
        queue_update(HALF_DEG, -HALF_DEG, 32767, -HALF_DEG, HALF_DEG, -32768, 0);
        queue_update(-32768, 32767, 0, 32767, -32768, 100, 65535);
        queue_update(100, -100, HALF_DEG - 1, 100 + HALF_DEG - 1, -100 - HALF_DEG + 1,
                     -HALF_DEG + 1, 1);
        queue_update(0, 0, 0, 1, -1, HALF_DEG - 1, 65535);
        queue_update(-HALF_DEG + 1, HALF_DEG, 5, HALF_DEG, -HALF_DEG + 1, 5, 4096);
        drain_pipeline();

        // zero half-life, so x saturates for the larger dt; widest in-range bias band
        write_reg(CFG_HALF_LIFE, 16'd0);
        write_reg(CFG_CCW_THRESHOLD, 16'd23040);
        queue_update(0, 0, 0, 100, -100, HALF_DEG, 65535);
        queue_update(1000, -1000, 0, 1000, -1000, 1, 1);
        queue_update(0, 0, 0, 0, 1, -1, 0);
        queue_update(-32768, 32767, -HALF_DEG, 0, 0, HALF_DEG, 200);
        queue_update(HALF_DEG, 0, -1, -HALF_DEG, 1, 1, 185);
        drain_pipeline();

        // longest half-life, band beyond a half turn, unmapped indexes
        write_reg(CFG_HALF_LIFE, 16'hFFFF);
        write_reg(CFG_CCW_THRESHOLD, 16'hFFFF);
        write_reg(CFG_SPARE_A, 16'h1234);
        write_reg(CFG_SPARE_B, 16'hFFFF);
        queue_update(0, 0, 0, HALF_DEG, -HALF_DEG, 1, 65535);
        queue_update(-32768, -32768, 32767, 32767, 32767, -32768, 65535);
        queue_update(HALF_DEG, 0, -HALF_DEG, -HALF_DEG, HALF_DEG / 2, HALF_DEG / 2, 30000);
        queue_update(0, 0, 0, 0, 0, 0, 0);
        queue_update(-1, 1, 12345, 1, -1, -12345, 1);
        drain_pipeline();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_settings(p);
            if (p == 3) hold_req = 1'b1;
            if (p == RANDOM_PHASES - 1) quiet = 1'b1;
            queue_random_updates(PHASE_ITEMS);
            drain_pipeline();
        end

        if (error_count == 0) begin
            $display("[exact_damper_angle_smoother] OK");
        end else begin
            $display("[exact_damper_angle_smoother] ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("[exact_damper_angle_smoother] ERROR");
        $finish;
    end

endmodule
